// ----- src/midi_track_delta_and_note_fixer_unit_defines.svh -----
// assertion macros for the midi track delta and note fixer
// used by the port checker, expects clk and rst_n in scope
`ifndef MIDI_TRACK_DELTA_AND_NOTE_FIXER_UNIT_DEFINES_SVH
`define MIDI_TRACK_DELTA_AND_NOTE_FIXER_UNIT_DEFINES_SVH

// same-cycle implication
`define MTDNF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MTDNF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mtdnf_pkg.sv -----
// types and constants of the midi track delta and note fixer
// no dependencies
`default_nettype none

package mtdnf_pkg;

    localparam int TIME_W   = 63;
    localparam int SCALE_W  = 48;
    localparam int DELTA_W  = 32;
    localparam int INST_W   = 8;
    localparam int PEND_W   = 6;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;
    localparam int A_LO_W   = 32;
    localparam int B_LO_W   = 24;
    localparam int PP_W     = A_LO_W + B_LO_W;
    localparam int PROD_W   = TIME_W + SCALE_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int MUL_STEPS = 4;

    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;

    typedef enum logic [2:0] {
        REG_TRACK_PORT    = 3'd0,
        REG_TRACK_CHANNEL = 3'd1,
        REG_FIX_DUPLICATES = 3'd2,
        REG_TIME_ORIGIN   = 3'd3,
        REG_PULSE_SCALE   = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOOK,
        S_MUL,
        S_SUM,
        S_RES,
        S_REP
    } state_t;

    typedef struct packed {
        logic [INST_W-1:0] inst;
        logic [PEND_W-1:0] pend;
    } note_entry_t;

endpackage

`default_nettype wire

// ----- src/mtdnf_if.sv -----
// event and result channel interfaces of the midi track delta and note fixer
// depends on mtdnf_pkg
`default_nettype none

interface mtdnf_evt_if;
    import mtdnf_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [TIME_W-1:0] event_time;
    logic [7:0]        event_port;
    logic [7:0]        status_byte;
    logic [6:0]        data_one;
    logic [6:0]        data_two;

    modport source (
        output valid, action, event_time, event_port, status_byte, data_one, data_two,
        input  ready
    );
    modport sink (
        input  valid, action, event_time, event_port, status_byte, data_one, data_two,
        output ready
    );
endinterface

interface mtdnf_res_if;
    import mtdnf_pkg::*;

    logic               valid;
    logic               ready;
    logic [DELTA_W-1:0] delta_pulses;
    logic [7:0]         out_status;
    logic [6:0]         out_data_one;
    logic [6:0]         out_data_two;
    logic               out_of_order;
    logic               last;

    modport source (
        output valid, delta_pulses, out_status, out_data_one, out_data_two,
               out_of_order, last,
        input  ready
    );
    modport sink (
        input  valid, delta_pulses, out_status, out_data_one, out_data_two,
               out_of_order, last,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/midi_track_delta_and_note_fixer_unit.sv -----
// start events, foreign events and held-back note-offs end without a result; other events
// pass through the read, look-up, multiply, sum and result states to the output register
// one event at a time: the input stays closed until the event is done, and the shared 32x24
// multiplier takes the 63x48 scale product in four partial products, then any repeats follow
// reset: asynchronous active low, config to defaults, note table valid bits cleared
`default_nettype none

module midi_track_delta_and_note_fixer_unit #(
    parameter int NOTE_COUNT      = 128,
    parameter int SCALE_FRAC_BITS = 40
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mtdnf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mtdnf_pkg::DATA_W-1:0] pwdata,
    output      logic [mtdnf_pkg::DATA_W-1:0] prdata,
    output      logic                       pready,
    mtdnf_evt_if.sink                       evt,
    mtdnf_res_if.source                     res
);
    import mtdnf_pkg::*;

    localparam int NOTE_AW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

    state_t state_reg, state_next;

    logic [7:0]         port_reg, port_next;
    logic [3:0]         chan_reg, chan_next;
    logic               fix_reg, fix_next;
    logic [TIME_W-1:0]  origin_reg, origin_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;

    logic               action_reg, action_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic [7:0]         eport_reg, eport_next;
    logic [7:0]         status_reg, status_next;
    logic [6:0]         d1_reg, d1_next;
    logic [6:0]         d2_reg, d2_next;

    logic               neg_reg, neg_next;
    logic [TIME_W-1:0]  mag_reg, mag_next;
    logic [SUM_W-1:0]   nqh_reg, nqh_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [PP_W-1:0]    pp_reg, pp_next;
    logic [1:0]         pp_sel_reg, pp_sel_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [SUM_W-1:0]   s_reg, s_next;
    logic [DELTA_W-1:0] prev_reg, prev_next;

    logic               on_upd_reg, on_upd_next;
    logic               clr_upd_reg, clr_upd_next;
    logic [PEND_W-1:0]  rep_reg, rep_next;

    logic               ovalid_reg, ovalid_next;
    logic [DELTA_W-1:0] odelta_reg, odelta_next;
    logic [7:0]         ostatus_reg, ostatus_next;
    logic [6:0]         od1_reg, od1_next;
    logic [6:0]         od2_reg, od2_next;
    logic               oooo_reg, oooo_next;
    logic               olast_reg, olast_next;

    note_entry_t        note_mem [NOTE_COUNT];
    logic [NOTE_COUNT-1:0] vld_reg;
    note_entry_t        ent_reg;
    logic               ent_vld_reg;
    note_entry_t        ent;
    logic [NOTE_AW-1:0] idx;
    logic               mem_we;
    note_entry_t        mem_wdata;
    logic               clear_all;

    logic               cfg_wr;
    logic [TIME_W:0]    diff_fwd;
    logic [TIME_W:0]    diff_rev;
    logic [A_LO_W-1:0]  a_sel;
    logic [B_LO_W-1:0]  b_sel;
    logic [PROD_W-1:0]  pp_shifted;
    logic [SUM_W-1:0]   a_term;
    logic [SUM_W-1:0]   s_shift;
    logic [DELTA_W-1:0] delta_calc;
    logic               ooo;
    logic [DELTA_W:0]   prev_sum;
    logic [3:0]         cmd;
    logic               tracked;
    logic               is_on;

    assign idx      = d1_reg[NOTE_AW-1:0];
    assign ent      = ent_vld_reg ? ent_reg : '0;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign cmd      = status_reg[7:4];
    assign tracked  = fix_reg && (cmd == CMD_NOTE_OFF || cmd == CMD_NOTE_ON)
                      && ({1'b0, d1_reg} < 8'(NOTE_COUNT));
    assign is_on    = (cmd == CMD_NOTE_ON) && (d2_reg != 7'd0);

    assign diff_fwd = {1'b0, time_reg} - {1'b0, origin_reg};
    assign diff_rev = {1'b0, origin_reg} - {1'b0, time_reg};

    assign a_sel = cnt_reg[1] ? A_LO_W'(mag_reg[TIME_W-1:A_LO_W]) : mag_reg[A_LO_W-1:0];
    assign b_sel = cnt_reg[0] ? scale_reg[SCALE_W-1:B_LO_W] : scale_reg[B_LO_W-1:0];

    always_comb
    begin
        case (pp_sel_reg)
            2'd0:    pp_shifted = PROD_W'(pp_reg);
            2'd1:    pp_shifted = PROD_W'(pp_reg) << B_LO_W;
            2'd2:    pp_shifted = PROD_W'(pp_reg) << A_LO_W;
            2'd3:    pp_shifted = PROD_W'(pp_reg) << (A_LO_W + B_LO_W);
            default: pp_shifted = '0;
        endcase
    end

    assign a_term     = neg_reg ? ~SUM_W'(acc_reg) : SUM_W'(acc_reg);
    assign s_shift    = s_reg >> SCALE_FRAC_BITS;
    assign delta_calc = (|s_shift[SUM_W-1:DELTA_W]) ? '1 : s_shift[DELTA_W-1:0];
    assign ooo        = s_reg[SUM_W-1] || (s_reg == '0);
    assign prev_sum   = {1'b0, prev_reg} + {1'b0, delta_calc};

    always_comb
    begin
        case (reg_idx_t'(paddr[ADDR_W-1:3]))
            REG_TRACK_PORT:     prdata = DATA_W'(port_reg);
            REG_TRACK_CHANNEL:  prdata = DATA_W'(chan_reg);
            REG_FIX_DUPLICATES: prdata = DATA_W'(fix_reg);
            REG_TIME_ORIGIN:    prdata = DATA_W'(origin_reg);
            REG_PULSE_SCALE:    prdata = DATA_W'(scale_reg);
            default:            prdata = '0;
        endcase
    end

    assign evt.ready        = (state_reg == S_IDLE);
    assign res.valid        = ovalid_reg;
    assign res.delta_pulses = odelta_reg;
    assign res.out_status   = ostatus_reg;
    assign res.out_data_one = od1_reg;
    assign res.out_data_two = od2_reg;
    assign res.out_of_order = oooo_reg;
    assign res.last         = olast_reg;

    always_comb
    begin
        state_next   = state_reg;
        port_next    = port_reg;
        chan_next    = chan_reg;
        fix_next     = fix_reg;
        origin_next  = origin_reg;
        scale_next   = scale_reg;
        action_next  = action_reg;
        time_next    = time_reg;
        eport_next   = eport_reg;
        status_next  = status_reg;
        d1_next      = d1_reg;
        d2_next      = d2_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        nqh_next     = nqh_reg;
        acc_next     = acc_reg;
        pp_next      = pp_reg;
        pp_sel_next  = pp_sel_reg;
        cnt_next     = cnt_reg;
        s_next       = s_reg;
        prev_next    = prev_reg;
        on_upd_next  = on_upd_reg;
        clr_upd_next = clr_upd_reg;
        rep_next     = rep_reg;
        ovalid_next  = ovalid_reg;
        odelta_next  = odelta_reg;
        ostatus_next = ostatus_reg;
        od1_next     = od1_reg;
        od2_next     = od2_reg;
        oooo_next    = oooo_reg;
        olast_next   = olast_reg;
        mem_we       = 1'b0;
        mem_wdata    = ent;
        clear_all    = 1'b0;

        if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[ADDR_W-1:3]))
                REG_TRACK_PORT:     port_next   = pwdata[7:0];
                REG_TRACK_CHANNEL:  chan_next   = pwdata[3:0];
                REG_FIX_DUPLICATES: fix_next    = pwdata[0];
                REG_TIME_ORIGIN:    origin_next = pwdata[TIME_W-1:0];
                REG_PULSE_SCALE:    scale_next  = pwdata[SCALE_W-1:0];
                default:            ;
            endcase
        end

        if (ovalid_reg && res.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (evt.valid)
                begin
                    action_next = evt.action;
                    time_next   = evt.event_time;
                    eport_next  = evt.event_port;
                    status_next = evt.status_byte;
                    d1_next     = evt.data_one;
                    d2_next     = evt.data_two;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                if (!action_reg)
                begin
                    clear_all  = 1'b1;
                    prev_next  = '0;
                    state_next = S_IDLE;
                end
                else if (eport_reg != port_reg || status_reg[3:0] != chan_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    neg_next   = diff_fwd[TIME_W];
                    mag_next   = diff_fwd[TIME_W] ? diff_rev[TIME_W-1:0]
                                                  : diff_fwd[TIME_W-1:0];
                    nqh_next   = (SUM_W'(1) << (SCALE_FRAC_BITS - 1))
                                 - (SUM_W'(prev_reg) << SCALE_FRAC_BITS);
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (tracked && !is_on && ent.inst > INST_W'(1))
                begin
                    // other instances still sound: hold this off back
                    mem_we         = 1'b1;
                    mem_wdata.inst = ent.inst - INST_W'(1);
                    mem_wdata.pend = (ent.pend == '1) ? ent.pend : ent.pend + PEND_W'(1);
                    state_next     = S_IDLE;
                end
                else
                begin
                    on_upd_next  = tracked && is_on;
                    clr_upd_next = tracked && !is_on && (ent.inst != '0);
                    rep_next     = (tracked && !is_on && (ent.inst != '0)) ? ent.pend : '0;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                if (cnt_reg < 3'(MUL_STEPS))
                begin
                    pp_next     = PP_W'(a_sel) * PP_W'(b_sel);
                    pp_sel_next = cnt_reg[1:0];
                end
                if (cnt_reg != '0)
                begin
                    acc_next = acc_reg + pp_shifted;
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(MUL_STEPS))
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                // signed time minus emitted pulses, plus half for rounding
                s_next     = a_term + nqh_reg + SUM_W'(neg_reg);
                state_next = S_RES;
            end
            S_RES:
            begin
                if (!ovalid_reg || res.ready)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = status_reg;
                    od1_next     = d1_reg;
                    od2_next     = d2_reg;
                    if (ooo)
                    begin
                        odelta_next = '0;
                        oooo_next   = 1'b1;
                        olast_next  = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        odelta_next = delta_calc;
                        oooo_next   = 1'b0;
                        olast_next  = (rep_reg == '0);
                        prev_next   = prev_sum[DELTA_W] ? '1 : prev_sum[DELTA_W-1:0];
                        if (on_upd_reg)
                        begin
                            mem_we         = 1'b1;
                            mem_wdata.inst = (ent.inst == '1) ? ent.inst
                                                              : ent.inst + INST_W'(1);
                            mem_wdata.pend = ent.pend;
                        end
                        else if (clr_upd_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = '0;
                        end
                        state_next = (rep_reg != '0) ? S_REP : S_IDLE;
                    end
                end
            end
            S_REP:
            begin
                if (res.ready)
                begin
                    ovalid_next = 1'b1;
                    odelta_next = '0;
                    oooo_next   = 1'b0;
                    olast_next  = (rep_reg == PEND_W'(1));
                    rep_next    = rep_reg - PEND_W'(1);
                    if (rep_reg == PEND_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            port_reg    <= '0;
            chan_reg    <= '0;
            fix_reg     <= 1'b1;
            origin_reg  <= '0;
            scale_reg   <= '0;
            prev_reg    <= '0;
            cnt_reg     <= '0;
            rep_reg     <= '0;
            on_upd_reg  <= 1'b0;
            clr_upd_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
            vld_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            port_reg    <= port_next;
            chan_reg    <= chan_next;
            fix_reg     <= fix_next;
            origin_reg  <= origin_next;
            scale_reg   <= scale_next;
            prev_reg    <= prev_next;
            cnt_reg     <= cnt_next;
            rep_reg     <= rep_next;
            on_upd_reg  <= on_upd_next;
            clr_upd_reg <= clr_upd_next;
            ovalid_reg  <= ovalid_next;
            if (clear_all)
            begin
                vld_reg <= '0;
            end
            else if (mem_we)
            begin
                vld_reg[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        time_reg    <= time_next;
        eport_reg   <= eport_next;
        status_reg  <= status_next;
        d1_reg      <= d1_next;
        d2_reg      <= d2_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        nqh_reg     <= nqh_next;
        acc_reg     <= acc_next;
        pp_reg      <= pp_next;
        pp_sel_reg  <= pp_sel_next;
        s_reg       <= s_next;
        odelta_reg  <= odelta_next;
        ostatus_reg <= ostatus_next;
        od1_reg     <= od1_next;
        od2_reg     <= od2_next;
        oooo_reg    <= oooo_next;
        olast_reg   <= olast_next;
    end

    // note table: one write port, registered read with its valid bit
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            note_mem[idx] <= mem_wdata;
        end
        if (state_reg == S_READ)
        begin
            ent_reg     <= note_mem[idx];
            ent_vld_reg <= vld_reg[idx];
        end
    end

endmodule

`default_nettype wire

// ----- src/mtdnf_checker.sv -----
// port checker for midi_track_delta_and_note_fixer_unit, bound to the top level
// depends on midi_track_delta_and_note_fixer_unit_defines.svh
`default_nettype none

`include "midi_track_delta_and_note_fixer_unit_defines.svh"

module mtdnf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        evt_valid,
    input wire logic        evt_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [31:0] res_delta_pulses,
    input wire logic        res_out_of_order,
    input wire logic        res_last
);

    // a stalled result transaction holds
    `MTDNF_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_delta_pulses) && $stable(res_last), "result changed while stalled")

    // out-of-order result is alone and carries no delta
    `MTDNF_ASSERT_NOW(a_ooo_single, res_valid && res_out_of_order, res_last && res_delta_pulses == 32'd0, "out-of-order result not single")

    // one event at a time
    `MTDNF_ASSERT_NEXT(a_busy_after_accept, evt_valid && evt_ready, !evt_ready, "event accepted while busy")

    // repeats still owed keep the input closed
    `MTDNF_ASSERT_NOW(a_no_accept_mid_burst, res_valid && !res_last, !evt_ready, "input open during repeat burst")

endmodule

bind midi_track_delta_and_note_fixer_unit mtdnf_checker u_mtdnf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .evt_valid        (evt.valid),
    .evt_ready        (evt.ready),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_delta_pulses (res.delta_pulses),
    .res_out_of_order (res.out_of_order),
    .res_last         (res.last)
);

`default_nettype wire
